// File: src/cemt_pkg.sv
`timescale 1ns / 1ps
package cemt_pkg;

    localparam int MaxExtents      = 128;
    localparam int MaxReadClusters = 63;

    localparam logic [11:0] ClusterBad = 12'hFF0;
    localparam logic [23:0] PosMax     = 24'hFFFFFF;
    localparam logic [11:0] RunMax     = 12'hFFF;
    localparam logic [11:0] ClusterMin = 12'd2;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_NOEXT    = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_BROKEN   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_RAW_BASE      = 3'd0,
        REG_IMAGE_SIZE    = 3'd1,
        REG_FAT_MODE      = 3'd2,
        REG_VOL_BASE      = 3'd3,
        REG_DATA_AREA     = 3'd4,
        REG_CLUSTER_SHIFT = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_WAIT,
        S_APP_DO,
        S_RD_CHK,
        S_RD_SPAN,
        S_WALK_RD,
        S_WALK_WAIT,
        S_WALK_CMP,
        S_CHUNK,
        S_OUT
    } state_t;

    // one stored extent
    typedef struct packed {
        logic [23:0] lstart;
        logic [11:0] pstart;
        logic [11:0] run;
    } extent_t;

    // result word held for the output stage
    typedef struct packed {
        status_t     status;
        logic [31:0] addr;
        logic [31:0] len;
        logic        last;
    } result_t;

endpackage

// File: src/cemt_ram.sv
`timescale 1ns / 1ps
module cemt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/cemt_cfg.sv
`timescale 1ns / 1ps
module cemt_cfg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic [31:0] raw_base,
    output logic [31:0] image_size,
    output logic        fat_mode,
    output logic [31:0] vol_base,
    output logic [31:0] data_area_off,
    output logic [3:0]  eff_shift
);

    logic [31:0] raw_base_reg, image_size_reg, vol_base_reg, data_area_off_reg;
    logic        fat_mode_reg;
    logic [3:0]  shift_reg;

    assign cfg_ready = 1'b1;

    // register file, written on handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_base_reg      <= '0;
            image_size_reg    <= '0;
            fat_mode_reg      <= 1'b0;
            vol_base_reg      <= '0;
            data_area_off_reg <= '0;
            shift_reg         <= 4'd9;
        end else if (cfg_valid) begin
            case (cemt_pkg::reg_idx_t'(cfg_index))
                cemt_pkg::REG_RAW_BASE:      raw_base_reg      <= cfg_data;
                cemt_pkg::REG_IMAGE_SIZE:    image_size_reg    <= cfg_data;
                cemt_pkg::REG_FAT_MODE:      fat_mode_reg      <= cfg_data[0];
                cemt_pkg::REG_VOL_BASE:      vol_base_reg      <= cfg_data;
                cemt_pkg::REG_DATA_AREA:     data_area_off_reg <= cfg_data;
                cemt_pkg::REG_CLUSTER_SHIFT: shift_reg         <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign raw_base      = raw_base_reg;
    assign image_size    = image_size_reg;
    assign fat_mode      = fat_mode_reg;
    assign vol_base      = vol_base_reg;
    assign data_area_off = data_area_off_reg;
    // clamp to 9..15; a 4-bit field never exceeds 15
    assign eff_shift     = (shift_reg < 4'd9) ? 4'd9 : shift_reg;

endmodule

// File: src/cluster_extent_map_translator_top.sv
`timescale 1ns / 1ps
// Extent map builder and read translator. Commands arrive one word at a time
// on s_axis (func 0 clear, 1 append cluster, 2 read, 3 no-op). Clear and no-op
// go straight to the output state; append first reads the last extent from the
// registered-read extent RAM (read, wait, then update states). A read that ends
// in a range error, an empty read, a plain-mode read or a broken map answers
// from the check state, a read spanning too many clusters from the span state.
// A mapped read walks the extent RAM one entry at a time (read, wait, compare)
// from the first entry for each cluster it touches; a further chunk's walk
// begins once the previous word has been taken, and a cluster with no extent
// ends the read with one no-extent word after the same walk. A read may emit up
// to MAX_READ_CLUSTERS chunks, the final one with tlast. The block takes no new
// word until the last result has been taken. Configuration writes are
// accepted at any time but must only be issued while the block is idle.
module cluster_extent_map_translator_top #(
    parameter int MAX_EXTENTS       = cemt_pkg::MaxExtents,
    parameter int MAX_READ_CLUSTERS = cemt_pkg::MaxReadClusters
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,   // cluster[11:0], offset[43:12], length[75:44]
    input  logic [1:0]   s_axis_tuser,   // func[1:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,   // status[2:0], chunk_address[34:3],
                                         // chunk_length[66:35], extent_total[74:67]
    output logic         m_axis_tuser,   // map_ok
    output logic         m_axis_tlast
);

    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int EW = $bits(cemt_pkg::extent_t);

    logic [31:0] raw_base, image_size, vol_base, data_area_off;
    logic        fat_mode;
    logic [3:0]  sh;

    cemt_cfg u_cfg (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .raw_base, .image_size, .fat_mode, .vol_base, .data_area_off,
        .eff_shift(sh)
    );

    cemt_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [23:0]      pos_reg, pos_next;
    logic             valid_reg, valid_next;
    logic [11:0]      cl_reg, cl_next;
    logic [31:0]      off_reg, off_next, len_reg, len_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [11:0]      phys_reg, phys_next;
    cemt_pkg::result_t res_reg, res_next;
    logic             ovalid_reg, ovalid_next;

    // extent RAM
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    cemt_pkg::extent_t wdata, rdata;
    logic [EW-1:0]     rraw;

    cemt_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_ram (
        .aclk, .we, .waddr, .wdata(wdata), .raddr, .rdata(rraw)
    );
    assign rdata = cemt_pkg::extent_t'(rraw);

    // shared datapath helpers
    logic [31:0] cs, cmask, in_clus, chunk;
    logic [32:0] span_sum;
    logic [32:0] span;
    logic [23:0] t;
    logic [23:0] tdiff;
    logic [24:0] lend;
    logic [12:0] pend;
    logic [31:0] room;

    assign cs       = 32'd1 << sh;
    assign cmask    = cs - 32'd1;
    assign in_clus  = off_reg & cmask;
    assign span_sum = {1'b0, in_clus} + {1'b0, len_reg} + {1'b0, cmask};
    assign span     = span_sum >> sh;
    assign t        = 24'(off_reg >> sh);
    assign tdiff    = t - rdata.lstart;
    assign lend     = {1'b0, rdata.lstart} + {13'd0, rdata.run};
    assign pend     = {1'b0, rdata.pstart} + {1'b0, rdata.run};
    assign room     = cs - in_clus;
    assign chunk    = (room > len_reg) ? len_reg : room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= cemt_pkg::S_IDLE;
            count_reg  <= '0;
            pos_reg    <= '0;
            valid_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            valid_reg  <= valid_next;
            ovalid_reg <= ovalid_next;
        end
        cl_reg   <= cl_next;
        off_reg  <= off_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        phys_reg <= phys_next;
        res_reg  <= res_next;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        valid_next  = valid_reg;
        cl_next     = cl_reg;
        off_next    = off_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        phys_next   = phys_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        we          = 1'b0;
        waddr       = AW'(count_reg);
        wdata       = '{lstart: pos_reg, pstart: cl_reg, run: 12'd1};
        raddr       = AW'(idx_reg);

        case (state_reg)
            cemt_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    cl_next  = s_axis_tdata[11:0];
                    off_next = s_axis_tdata[43:12];
                    len_next = s_axis_tdata[75:44];
                    res_next = '{status: cemt_pkg::ST_OK, addr: '0, len: '0, last: 1'b1};
                    case (cemt_pkg::func_t'(s_axis_tuser))
                        cemt_pkg::FUNC_CLEAR: begin
                            count_next = '0;
                            pos_next   = '0;
                            valid_next = 1'b1;
                            state_next = cemt_pkg::S_OUT;
                        end
                        cemt_pkg::FUNC_APPEND: begin
                            idx_next   = count_reg - CW'(1);
                            state_next = cemt_pkg::S_APP_RD;
                        end
                        cemt_pkg::FUNC_READ: state_next = cemt_pkg::S_RD_CHK;
                        default: state_next = cemt_pkg::S_OUT;
                    endcase
                end
            end
            cemt_pkg::S_APP_RD: state_next = cemt_pkg::S_APP_WAIT;
            cemt_pkg::S_APP_WAIT: state_next = cemt_pkg::S_APP_DO;
            cemt_pkg::S_APP_DO: begin
                state_next = cemt_pkg::S_OUT;
                if (!valid_reg) begin
                    res_next.status = cemt_pkg::ST_BROKEN;
                end else if (cl_reg < cemt_pkg::ClusterMin || cl_reg >= cemt_pkg::ClusterBad
                             || pos_reg == cemt_pkg::PosMax) begin
                    valid_next      = 1'b0;
                    res_next.status = cemt_pkg::ST_BROKEN;
                end else if (count_reg != '0 && {1'b0, cl_reg} == pend
                             && rdata.run != cemt_pkg::RunMax) begin
                    we         = 1'b1;
                    waddr      = AW'(idx_reg);
                    wdata      = '{lstart: rdata.lstart, pstart: rdata.pstart,
                                   run: rdata.run + 12'd1};
                    pos_next   = pos_reg + 24'd1;
                end else if (count_reg == CW'(MAX_EXTENTS)) begin
                    valid_next      = 1'b0;
                    res_next.status = cemt_pkg::ST_BROKEN;
                end else begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                    pos_next   = pos_reg + 24'd1;
                end
            end
            cemt_pkg::S_RD_CHK: begin
                state_next = cemt_pkg::S_OUT;
                if (off_reg > image_size || len_reg > image_size - off_reg) begin
                    res_next.status = cemt_pkg::ST_RANGE;
                end else if (len_reg == '0) begin
                    res_next.status = cemt_pkg::ST_OK;
                end else if (!fat_mode) begin
                    res_next.addr = raw_base + off_reg;
                    res_next.len  = len_reg;
                end else if (!valid_reg) begin
                    res_next.status = cemt_pkg::ST_BROKEN;
                end else begin
                    state_next = cemt_pkg::S_RD_SPAN;
                end
            end
            cemt_pkg::S_RD_SPAN: begin
                if (span > 33'(MAX_READ_CLUSTERS)) begin
                    res_next.status = cemt_pkg::ST_TOO_LONG;
                    state_next      = cemt_pkg::S_OUT;
                end else begin
                    idx_next   = '0;
                    state_next = cemt_pkg::S_WALK_RD;
                end
            end
            cemt_pkg::S_WALK_RD: begin
                if (idx_reg == count_reg) begin
                    res_next   = '{status: cemt_pkg::ST_NOEXT, addr: '0, len: '0, last: 1'b1};
                    state_next = cemt_pkg::S_OUT;
                end else begin
                    state_next = cemt_pkg::S_WALK_WAIT;
                end
            end
            cemt_pkg::S_WALK_WAIT: state_next = cemt_pkg::S_WALK_CMP;
            cemt_pkg::S_WALK_CMP: begin
                if (t >= rdata.lstart && {1'b0, t} < lend) begin
                    phys_next  = rdata.pstart + tdiff[11:0];
                    state_next = cemt_pkg::S_CHUNK;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = cemt_pkg::S_WALK_RD;
                end
            end
            cemt_pkg::S_CHUNK: begin
                res_next.status = cemt_pkg::ST_OK;
                res_next.addr   = vol_base + data_area_off
                                  + ({20'd0, phys_reg - 12'd2} << sh) + in_clus;
                res_next.len    = chunk;
                res_next.last   = (len_reg == chunk);
                len_next        = len_reg - chunk;
                off_next        = off_reg + chunk;
                state_next      = cemt_pkg::S_OUT;
            end
            cemt_pkg::S_OUT: begin
                ovalid_next = 1'b1;
                if (ovalid_reg && m_axis_tready) begin
                    ovalid_next = 1'b0;
                    if (!res_reg.last) begin
                        idx_next   = '0;
                        state_next = cemt_pkg::S_WALK_RD;
                    end else begin
                        state_next = cemt_pkg::S_IDLE;
                    end
                end
            end
            default: state_next = cemt_pkg::S_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == cemt_pkg::S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {5'd0, 8'(count_reg), res_reg.len, res_reg.addr, res_reg.status};
    assign m_axis_tuser  = valid_reg & fat_mode;
    assign m_axis_tlast  = res_reg.last;

endmodule

// File: src/cemt_checker.sv
`timescale 1ns / 1ps
module cemt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // never accept input while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // status stays in its code range
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= cemt_pkg::ST_BROKEN)
        else $error("bad status code");

    // error results carry no chunk and end the input
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[2:0] != cemt_pkg::ST_OK) |-> m_axis_tlast)
        else $error("error result without last");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");

endmodule

bind cluster_extent_map_translator_top cemt_checker u_cemt_checker (
    .aclk, .aresetn, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

// File: tb/cemt_checker.sv
`timescale 1ns / 1ps
// Watches the command, config and result channels, runs its own copy of the
// extent map and compares every result word with the oldest expected one.
module cemt_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [2:0]  status;
        logic [31:0] addr;
        logic [31:0] len;
        logic [7:0]  total;
        logic        ok;
        logic        last;
    } chunk_word_t;

    chunk_word_t expected_chunks[$];

    // shadow registers
    logic [31:0] raw_base, image_size, vol_base, data_area_off;
    logic        fat_mode;
    logic [3:0]  cluster_shift;

    // shadow extent map
    logic [23:0] ext_lstart [cemt_pkg::MaxExtents];
    logic [11:0] ext_pstart [cemt_pkg::MaxExtents];
    logic [11:0] ext_run    [cemt_pkg::MaxExtents];
    int unsigned ext_count;
    logic [23:0] chain_pos;
    logic        map_valid;

    assign pending = expected_chunks.size();

    task automatic push_word(cemt_pkg::status_t st, logic [31:0] addr, logic [31:0] len,
                             logic last);
        chunk_word_t w;
        w.status = st;
        w.addr   = addr;
        w.len    = len;
        w.total  = ext_count[7:0];
        w.ok     = map_valid && fat_mode;
        w.last   = last;
        expected_chunks.push_back(w);
    endtask

    function automatic cemt_pkg::status_t append_cluster(logic [11:0] cl);
        int unsigned e;
        if (!map_valid) return cemt_pkg::ST_BROKEN;
        if (cl < cemt_pkg::ClusterMin || cl >= cemt_pkg::ClusterBad ||
            chain_pos >= cemt_pkg::PosMax) begin
            map_valid = 1'b0;
            return cemt_pkg::ST_BROKEN;
        end
        if (ext_count != 0) begin
            e = ext_count - 1;
            if ({20'd0, cl} == {20'd0, ext_pstart[e]} + {20'd0, ext_run[e]} &&
                ext_run[e] < cemt_pkg::RunMax) begin
                ext_run[e] = ext_run[e] + 1'b1;
                chain_pos  = chain_pos + 1'b1;
                return cemt_pkg::ST_OK;
            end
        end
        if (ext_count >= cemt_pkg::MaxExtents) begin
            map_valid = 1'b0;
            return cemt_pkg::ST_BROKEN;
        end
        ext_lstart[ext_count] = chain_pos;
        ext_pstart[ext_count] = cl;
        ext_run[ext_count]    = 12'd1;
        ext_count++;
        chain_pos = chain_pos + 1'b1;
        return cemt_pkg::ST_OK;
    endfunction

    // expected chunks of one read request
    task automatic translate_read(logic [31:0] off, logic [31:0] len);
        int unsigned sh;
        logic [31:0] cs, in_clus, t, phys, chunk;
        logic [63:0] span;
        bit found;
        if (off > image_size || len > image_size - off) begin
            push_word(cemt_pkg::ST_RANGE, '0, '0, 1'b1);
            return;
        end
        if (len == 0) begin
            push_word(cemt_pkg::ST_OK, '0, '0, 1'b1);
            return;
        end
        if (!fat_mode) begin
            push_word(cemt_pkg::ST_OK, raw_base + off, len, 1'b1);
            return;
        end
        if (!map_valid) begin
            push_word(cemt_pkg::ST_BROKEN, '0, '0, 1'b1);
            return;
        end
        sh = (cluster_shift < 9) ? 9 : cluster_shift;
        cs = 32'd1 << sh;
        in_clus = off & (cs - 1);
        span = ({32'd0, in_clus} + {32'd0, len} + {32'd0, cs} - 64'd1) >> sh;
        if (span > cemt_pkg::MaxReadClusters) begin
            push_word(cemt_pkg::ST_TOO_LONG, '0, '0, 1'b1);
            return;
        end
        while (len != 0) begin
            t = off >> sh;
            found = 0;
            phys = 0;
            for (int unsigned i = 0; i < ext_count; i++) begin
                if (t >= ext_lstart[i] && t < {8'd0, ext_lstart[i]} + ext_run[i]) begin
                    phys = ext_pstart[i] + (t - ext_lstart[i]);
                    found = 1;
                    break;
                end
            end
            if (!found) begin
                push_word(cemt_pkg::ST_NOEXT, '0, '0, 1'b1);
                return;
            end
            in_clus = off & (cs - 1);
            chunk = cs - in_clus;
            if (chunk > len) chunk = len;
            len = len - chunk;
            push_word(cemt_pkg::ST_OK,
                      vol_base + data_area_off + ((phys - 2) << sh) + in_clus,
                      chunk, len == 0);
            off = off + chunk;
        end
    endtask

    task automatic predict_command(logic [1:0] f, logic [79:0] d);
        case (cemt_pkg::func_t'(f))
            cemt_pkg::FUNC_CLEAR: begin
                ext_count = 0;
                chain_pos = 0;
                map_valid = 1'b1;
                push_word(cemt_pkg::ST_OK, '0, '0, 1'b1);
            end
            cemt_pkg::FUNC_APPEND: push_word(append_cluster(d[11:0]), '0, '0, 1'b1);
            cemt_pkg::FUNC_READ:   translate_read(d[43:12], d[75:44]);
            default:               push_word(cemt_pkg::ST_OK, '0, '0, 1'b1);
        endcase
    endtask

    always @(posedge aclk) begin
        chunk_word_t w;
        if (!aresetn) begin
            raw_base = 0; image_size = 0; fat_mode = 0;
            vol_base = 0; data_area_off = 0; cluster_shift = 4'd9;
            ext_count = 0; chain_pos = 0; map_valid = 0;
            errors = 0;
            expected_chunks.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cemt_pkg::reg_idx_t'(cfg_index))
                    cemt_pkg::REG_RAW_BASE:      raw_base      = cfg_data;
                    cemt_pkg::REG_IMAGE_SIZE:    image_size    = cfg_data;
                    cemt_pkg::REG_FAT_MODE:      fat_mode      = cfg_data[0];
                    cemt_pkg::REG_VOL_BASE:      vol_base      = cfg_data;
                    cemt_pkg::REG_DATA_AREA:     data_area_off = cfg_data;
                    cemt_pkg::REG_CLUSTER_SHIFT: cluster_shift = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_command(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_chunks.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual data=%h user=%b last=%b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    errors++;
                end else begin
                    w = expected_chunks.pop_front();
                    if (m_axis_tdata[2:0] !== w.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, w.status, m_axis_tdata[2:0]);
                        errors++;
                    end
                    if (m_axis_tdata[34:3] !== w.addr) begin
                        $display("%0t: chunk_address expected %h actual %h",
                                 $time, w.addr, m_axis_tdata[34:3]);
                        errors++;
                    end
                    if (m_axis_tdata[66:35] !== w.len) begin
                        $display("%0t: chunk_length expected %h actual %h",
                                 $time, w.len, m_axis_tdata[66:35]);
                        errors++;
                    end
                    if (m_axis_tdata[74:67] !== w.total) begin
                        $display("%0t: extent_total expected %0d actual %0d",
                                 $time, w.total, m_axis_tdata[74:67]);
                        errors++;
                    end
                    if (m_axis_tuser !== w.ok) begin
                        $display("%0t: map_ok expected %b actual %b",
                                 $time, w.ok, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tlast !== w.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, w.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict: directed corner cases, then randomized chain building
// and read traffic under four idle/stall mixes.
module testbench;

    localparam int WatchdogLimit = 20000;

    logic        aclk, aresetn;
    logic        s_axis_tvalid, s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser, m_axis_tlast;
    int          errors, pending;
    int          gap_pct, stall_pct;
    int          idle_count = 0;

    cluster_extent_map_translator_top dut (.*);

    cemt_monitor u_monitor (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // receiver stalls
    always @(posedge aclk)
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(1, 100) > stall_pct);

    // watchdog on cycles without any word moving
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !aresetn)
            idle_count <= 0;
        else if (idle_count >= WatchdogLimit) begin
            $display("cluster_extent_map_translator_top: mismatch");
            $finish;
        end else
            idle_count <= idle_count + 1;
    end

    task automatic send(cemt_pkg::func_t f, logic [11:0] cl, logic [31:0] off,
                        logic [31:0] len);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(1, 100) <= gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {4'd0, len, off, cl};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic read(logic [31:0] off, logic [31:0] len);
        send(cemt_pkg::FUNC_READ, 12'($urandom), off, len);
    endtask

    task automatic append(logic [11:0] cl);
        send(cemt_pkg::FUNC_APPEND, cl, $urandom, $urandom);
    endtask

    // block goes quiet before registers change
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic cfg_write(cemt_pkg::reg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(logic [31:0] rb, logic [31:0] isz, logic fm,
                             logic [31:0] vb, logic [31:0] doff, logic [3:0] sh);
        cfg_write(cemt_pkg::REG_RAW_BASE, rb);
        cfg_write(cemt_pkg::REG_IMAGE_SIZE, isz);
        cfg_write(cemt_pkg::REG_FAT_MODE, {31'd0, fm});
        cfg_write(cemt_pkg::REG_VOL_BASE, vb);
        cfg_write(cemt_pkg::REG_DATA_AREA, doff);
        cfg_write(cemt_pkg::REG_CLUSTER_SHIFT, {28'd0, sh});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned n, cs, sh, cur, off, len, pick;
        aresetn = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        gap_pct = 0; stall_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // plain mode: wrapped address, empty reads, range edges, append to an uncleared map
        configure(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 4'd9);
        read(32'h20, 32'h100);
        read(32'h0, 32'h0);
        read(32'hFFFF_FFFF, 32'h1);
        read(32'hFFFF_FFFF, 32'h0);
        send(cemt_pkg::FUNC_NOP, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        append(12'd5);
        drain();

        // mapped mode, shift below range clamps to 512-byte clusters
        configure(32'h0, 32'h0100_0000, 1'b1, 32'h8000_0000, 32'h4000, 4'd3);
        read(32'h0, 32'h10);
        send(cemt_pkg::FUNC_CLEAR, '0, '0, '0);
        append(12'd2); append(12'd3); append(12'd4);
        append(12'd10); append(12'd11); append(12'h20);
        read(32'h0, 32'd3072);
        read(32'd100, 32'd700);
        read(32'h0, 32'd32768);
        read(32'd2560, 32'd1024);
        read(32'h0100_0001, 32'h0);
        append(12'd0);
        read(32'h0, 32'h10);
        send(cemt_pkg::FUNC_CLEAR, '0, '0, '0);
        append(12'd1);
        send(cemt_pkg::FUNC_CLEAR, '0, '0, '0);
        append(cemt_pkg::ClusterBad);
        send(cemt_pkg::FUNC_CLEAR, '0, '0, '0);
        append(12'hFEF);
        read(32'h0, 32'h1);
        drain();

        // largest cluster size, wrapping data-area address
        configure(32'h0, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678, 32'hFFFF_0000, 4'd15);
        send(cemt_pkg::FUNC_CLEAR, '0, '0, '0);
        append(12'd2); append(12'd4); append(12'd5); append(12'd9);
        read(32'h0, 32'h8001);
        read(32'd1 << 15, 32'h10000);
        read(32'd5 << 15, 32'h10);
        drain();

        // random phases: none, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 53; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 17; stall_pct = 17; end
            endcase
            pick = $urandom_range(0, 2);
            sh = (pick == 0) ? 9 : (pick == 1) ? 15 : $urandom_range(0, 15);
            cs = 1 << ((sh < 9) ? 9 : sh);
            configure($urandom, ($urandom_range(0, 4) != 0) ? 32'hFFFF_FFFF : $urandom,
                      $urandom_range(0, 4) != 0, $urandom, $urandom, 4'(sh));
            send(cemt_pkg::FUNC_CLEAR, '0, '0, '0);
            n = $urandom_range(1, 12);
            cur = $urandom_range(2, 32'hFEF);
            for (int i = 0; i < n; i++) begin
                append(12'(cur));
                if ($urandom_range(0, 9) < 7 && cur < 32'hFEF) cur++;
                else cur = $urandom_range(2, 32'hFEF);
            end
            repeat (13) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    off = $urandom_range(0, (n + 1) * cs);
                    case ($urandom_range(0, 3))
                        0: len = $urandom_range(1, 16);
                        1: len = $urandom_range(1, 2 * cs);
                        2: len = $urandom_range(1, 70 * cs);
                        default: len = 0;
                    endcase
                    read(off, len);
                end else if (pick < 70) begin
                    append(12'($urandom));
                end else if (pick < 80) begin
                    send(cemt_pkg::FUNC_NOP, 12'($urandom), $urandom, $urandom);
                end else if (pick < 85) begin
                    send(cemt_pkg::FUNC_CLEAR, 12'($urandom), $urandom, $urandom);
                end else begin
                    read($urandom, $urandom);
                end
            end
            drain();
        end

        repeat (400) @(posedge aclk);
        if (errors == 0)
            $display("cluster_extent_map_translator_top: match");
        else
            $display("cluster_extent_map_translator_top: mismatch");
        $finish;
    end

endmodule
